### sv/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared payload types and slot codes for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DW = 17;

    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic [1:0]           slot;
    } t_side;

endpackage

### sv/rmq_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_ifs
// Valid/ready channels for matrices in and quaternions out.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
    logic          valid;
    logic          ready;
    rmq_pkg::t_mat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if;
    logic           valid;
    logic           ready;
    rmq_pkg::t_quat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Two stages: trace, diagonal compares, off-diagonal sums and differences,
// then branch selection, radicand and routing of the three side lanes.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int FRAC_BITS = 14,
    parameter int SW        = 20,
    parameter int VW        = 34
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  rmq_pkg::t_mat   i_mat,
    output logic            o_vld,
    output logic [VW-1:0]   o_v,
    output rmq_pkg::t_side  o_side
);
    import rmq_pkg::*;

    logic                 r1_vld;
    logic signed [17:0]   r1_trace, r1_rad0, r1_rad1, r1_rad2;
    logic                 r1_gt01, r1_gt02, r1_gt12;
    logic signed [DW-1:0] r1_dif0, r1_dif1, r1_dif2, r1_sum01, r1_sum02, r1_sum12;

    logic signed [17:0] e00, e11, e22;
    assign e00 = 18'(i_mat.m00);
    assign e11 = 18'(i_mat.m11);
    assign e22 = 18'(i_mat.m22);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_trace <= e00 + e11 + e22;
            r1_rad0  <= e00 - e11 - e22;
            r1_rad1  <= e11 - e22 - e00;
            r1_rad2  <= e22 - e00 - e11;
            r1_gt01  <= i_mat.m11 > i_mat.m00;
            r1_gt02  <= i_mat.m22 > i_mat.m00;
            r1_gt12  <= i_mat.m22 > i_mat.m11;
            r1_dif0  <= DW'(i_mat.m12) - DW'(i_mat.m21);
            r1_dif1  <= DW'(i_mat.m20) - DW'(i_mat.m02);
            r1_dif2  <= DW'(i_mat.m01) - DW'(i_mat.m10);
            r1_sum01 <= DW'(i_mat.m01) + DW'(i_mat.m10);
            r1_sum02 <= DW'(i_mat.m02) + DW'(i_mat.m20);
            r1_sum12 <= DW'(i_mat.m12) + DW'(i_mat.m21);
        end
    end

    logic [1:0]         c_sel;
    logic signed [17:0] c_base;
    logic signed [SW-1:0] c_s;
    t_side              n_side;
    logic [VW-1:0]      n_v;

    always_comb begin
        if (r1_gt01) begin
            c_sel = r1_gt12 ? SLOT_Z : SLOT_Y;
        end else begin
            c_sel = r1_gt02 ? SLOT_Z : SLOT_X;
        end
        if (r1_trace > 0) begin
            c_base = r1_trace;
            n_side = '{d0: r1_dif0, d1: r1_dif1, d2: r1_dif2, slot: SLOT_W};
        end else begin
            case (c_sel)
                SLOT_X: begin
                    c_base = r1_rad0;
                    n_side = '{d0: r1_sum01, d1: r1_sum02, d2: r1_dif0, slot: SLOT_X};
                end
                SLOT_Y: begin
                    c_base = r1_rad1;
                    n_side = '{d0: r1_sum01, d1: r1_sum12, d2: r1_dif1, slot: SLOT_Y};
                end
                default: begin
                    c_base = r1_rad2;
                    n_side = '{d0: r1_sum02, d1: r1_sum12, d2: r1_dif2, slot: SLOT_Z};
                end
            endcase
        end
        c_s = SW'(c_base) + (SW'(1) <<< FRAC_BITS);
        n_v = (c_s > 0) ? (VW'(c_s) << FRAC_BITS) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v    <= n_v;
            o_side <= n_side;
        end
    end

endmodule

### sv/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int RW = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [2*RW-1:0]  i_v,
    input  rmq_pkg::t_side   i_side,
    output logic             o_vld,
    output logic [RW-1:0]    o_root,
    output rmq_pkg::t_side   o_side
);
    import rmq_pkg::*;

    localparam int VW = 2 * RW;

    logic [VW-1:0] r_v    [RW];
    logic [VW-1:0] r_r    [RW];
    t_side         r_side [RW];
    logic [RW-1:0] r_vld;

    for (genvar gs = 0; gs < RW; gs++) begin : g_st
        logic [VW-1:0] vi, ri, bt, tr, n_v, n_r;
        t_side         sd;
        logic          vl;
        if (gs == 0) begin : g_first
            assign vi = i_v;
            assign ri = '0;
            assign sd = i_side;
            assign vl = i_vld;
        end else begin : g_next
            assign vi = r_v[gs-1];
            assign ri = r_r[gs-1];
            assign sd = r_side[gs-1];
            assign vl = r_vld[gs-1];
        end
        assign bt  = VW'(1) << (2 * (RW - 1 - gs));
        assign tr  = ri + bt;
        assign n_v = (vi >= tr) ? vi - tr : vi;
        assign n_r = (vi >= tr) ? (ri >> 1) + bt : ri >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= vl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[gs]    <= n_v;
                r_r[gs]    <= n_r;
                r_side[gs] <= sd;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_r[RW-1][RW-1:0];
    assign o_side = r_side[RW-1];

endmodule

### sv/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider for d * 2^F / (2 * root), rounded,
// one quotient bit per stage, plus the rounded diagonal term.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int FRAC_BITS = 14,
    parameter int RW        = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [RW-1:0]   i_root,
    input  rmq_pkg::t_side  i_side,
    output logic            o_vld,
    output logic [16:0]     o_q [3],
    output logic [2:0]      o_neg,
    output logic [2:0]      o_zero,
    output logic [RW-1:0]   o_diag,
    output logic [1:0]      o_slot
);
    import rmq_pkg::*;

    localparam int QB = 17;
    localparam int NS = QB + 1;
    localparam int NW = 18 + FRAC_BITS;
    localparam int CW = ((NW > RW + 17) ? NW : RW + 17) + 1;

    logic [CW-1:0] r_rem  [NS][3];
    logic [QB-1:0] r_q    [NS][3];
    logic [2:0]    r_neg  [NS];
    logic [2:0]    r_zero [NS];
    logic [RW:0]   r_d    [NS];
    logic [RW-1:0] r_diag [NS];
    logic [1:0]    r_slot [NS];
    logic [NS-1:0] r_vld;

    logic signed [DW-1:0] c_d [3];
    assign c_d[0] = i_side.d0;
    assign c_d[1] = i_side.d1;
    assign c_d[2] = i_side.d2;

    logic [RW-1:0] n_diag0;

    always_comb begin
        logic [RW:0] rt;
        rt = {1'b0, i_root} + 1'b1;
        n_diag0 = rt[RW:1];
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_prep
        logic [17:0] mag;
        logic        neg;
        assign neg = c_d[gl] < 0;
        assign mag = neg ? -18'(c_d[gl]) : 18'(c_d[gl]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][gl]  <= (CW'(mag) << FRAC_BITS) + CW'(i_root);
                r_q[0][gl]    <= '0;
                r_neg[0][gl]  <= neg;
                r_zero[0][gl] <= (mag == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= {i_root, 1'b0};
            r_diag[0] <= n_diag0;
            r_slot[0] <= i_side.slot;
        end
    end

    for (genvar gs = 1; gs < NS; gs++) begin : g_st
        localparam int B = QB - gs;
        logic [CW-1:0] sh;
        assign sh = CW'(r_d[gs-1]) << B;
        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic          ge;
            logic [QB-1:0] n_q;
            assign ge = r_rem[gs-1][gl] >= sh;
            always_comb begin
                n_q    = r_q[gs-1][gl];
                n_q[B] = ge;
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gs][gl] <= ge ? r_rem[gs-1][gl] - sh : r_rem[gs-1][gl];
                    r_q[gs][gl]   <= n_q;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= r_vld[gs-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[gs]  <= r_neg[gs-1];
                r_zero[gs] <= r_zero[gs-1];
                r_d[gs]    <= r_d[gs-1];
                r_diag[gs] <= r_diag[gs-1];
                r_slot[gs] <= r_slot[gs-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_q    = r_q[NS-1];
    assign o_neg  = r_neg[NS-1];
    assign o_zero = r_zero[NS-1];
    assign o_diag = r_diag[NS-1];
    assign o_slot = r_slot[NS-1];

endmodule

### sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed-point rotation matrix to unit quaternion, fully pipelined.
//
//   channel   dir   payload                         handshake
//   i_mat     in    m00..m22, signed Q1.14          valid/ready
//   o_quat    out   quat_x/y/z/w, signed Q1.14      valid/ready
//
// One transaction per cycle while o_quat is not stalled. Data passes through
// the front, root (RW bits, 17 at FRAC_BITS = 14), divider and output register.
// Reset clears all stage valid bits. A stall on o_quat freezes the whole
// pipeline; i_mat.ready drops only while the output register is held.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    localparam int SW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int VB = SW - 1 + FRAC_BITS;
    localparam int RW = (VB + 1) / 2;

    logic          r_out_vld;
    t_quat         r_out;
    logic          c_en;

    logic          f_vld;
    logic [2*RW-1:0] f_v;
    t_side         f_side;
    logic          s_vld;
    logic [RW-1:0] s_root;
    t_side         s_side;
    logic          d_vld;
    logic [16:0]   d_q [3];
    logic [2:0]    d_neg, d_zero;
    logic [RW-1:0] d_diag;
    logic [1:0]    d_slot;

    assign c_en        = !r_out_vld || o_quat.ready;
    assign i_mat.ready = c_en;

    rmq_front #(.FRAC_BITS(FRAC_BITS), .SW(SW), .VW(2 * RW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(c_en),
        .i_vld(i_mat.valid), .i_mat(i_mat.data),
        .o_vld(f_vld), .o_v(f_v), .o_side(f_side)
    );

    rmq_sqrt #(.RW(RW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(c_en),
        .i_vld(f_vld), .i_v(f_v), .i_side(f_side),
        .o_vld(s_vld), .o_root(s_root), .o_side(s_side)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(c_en),
        .i_vld(s_vld), .i_root(s_root), .i_side(s_side),
        .o_vld(d_vld), .o_q(d_q), .o_neg(d_neg), .o_zero(d_zero),
        .o_diag(d_diag), .o_slot(d_slot)
    );

    function automatic logic signed [15:0] f_lane(logic [16:0] q, logic neg, logic zero);
        logic signed [15:0] res;
        if (zero) begin
            res = '0;
        end else if (neg) begin
            res = (q[16] || q[15]) ? 16'sh8000 : -$signed(q[15:0]);
        end else begin
            res = (q[16] || q[15]) ? 16'sh7fff : $signed(q[15:0]);
        end
        return res;
    endfunction

    logic [RW+15:0]     c_dext;
    logic signed [15:0] c_dg, c_l0, c_l1, c_l2;
    t_quat              n_out;

    always_comb begin
        c_dext = (RW + 16)'(d_diag);
        c_dg   = (c_dext > (RW + 16)'(32767)) ? 16'sh7fff : $signed(c_dext[15:0]);
        c_l0   = f_lane(d_q[0], d_neg[0], d_zero[0]);
        c_l1   = f_lane(d_q[1], d_neg[1], d_zero[1]);
        c_l2   = f_lane(d_q[2], d_neg[2], d_zero[2]);
        case (d_slot)
            SLOT_X:  n_out = '{quat_x: c_dg, quat_y: c_l0, quat_z: c_l1, quat_w: c_l2};
            SLOT_Y:  n_out = '{quat_x: c_l0, quat_y: c_dg, quat_z: c_l1, quat_w: c_l2};
            SLOT_Z:  n_out = '{quat_x: c_l0, quat_y: c_l1, quat_z: c_dg, quat_w: c_l2};
            default: n_out = '{quat_x: c_l0, quat_y: c_l1, quat_z: c_l2, quat_w: c_dg};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (c_en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_out <= n_out;
        end
    end

    assign o_quat.valid = r_out_vld;
    assign o_quat.data  = r_out;

endmodule
